### sv/rbd_pkg.sv
package rbd_pkg;

	// default number of words in the circular store
	localparam int DEPTH_DEF = 128;

	// fixed field widths of the stream payloads
	localparam int OP_W   = 3;
	localparam int WORD_W = 32;
	localparam int STAT_W = 2;
	localparam int OCC_W  = 8;

	// operation codes
	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
	localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
	localparam logic [OP_W-1:0] OP_PEEK_FRONT = 3'd4;
	localparam logic [OP_W-1:0] OP_PEEK_BACK  = 3'd5;
	localparam logic [OP_W-1:0] OP_CLEAR      = 3'd6;

	// result status codes
	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

	// command from controller to datapath
	typedef struct packed {
		logic take;   // accept the request and load the result register
	} rbd_cmd_t;

endpackage

### sv/rbd_ctrl.sv
module rbd_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	output logic             m_tvalid,
	input  logic             m_tready,
	output rbd_pkg::rbd_cmd_t cmd
);
	import rbd_pkg::*;

	// state of the result register
	localparam logic ST_EMPTY = 1'b0;
	localparam logic ST_HOLD  = 1'b1;

	logic state_q;
	logic state_d;

	// take a request whenever the result slot is free or being drained
	assign s_tready = (state_q == ST_EMPTY) || m_tready;
	assign m_tvalid = (state_q == ST_HOLD);
	assign cmd.take = s_tvalid && s_tready;

	// advance the slot state
	always_comb begin
		case (state_q)
			ST_EMPTY: state_d = cmd.take ? ST_HOLD : ST_EMPTY;
			ST_HOLD:  state_d = (cmd.take || !m_tready) ? ST_HOLD : ST_EMPTY;
			default:  state_d = ST_EMPTY;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_EMPTY;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### sv/rbd_dpath.sv
module rbd_dpath #(
	parameter int DEPTH = rbd_pkg::DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rbd_pkg::rbd_cmd_t           cmd,
	input  logic [rbd_pkg::OP_W-1:0]    opcode,
	input  logic signed [rbd_pkg::WORD_W-1:0] data_in,
	output logic signed [rbd_pkg::WORD_W-1:0] data_out,
	output logic [rbd_pkg::STAT_W-1:0]  status,
	output logic [rbd_pkg::OCC_W-1:0]   occupancy
);
	import rbd_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [WORD_W-1:0] mem [DEPTH];

	logic [AW-1:0] head_q, tail_q, head_d, tail_d;
	logic [CW-1:0] count_q, count_d;
	logic [STAT_W-1:0] status_q, stat_d;
	logic hit_q;
	logic [WORD_W-1:0] rd_q;

	logic [AW-1:0] head_inc, head_dec, tail_inc, tail_dec;
	logic [AW-1:0] waddr, raddr;
	logic we, re, full, empty;
	logic [CW+OCC_W-1:0] count_ext;

	assign full  = (count_q == FULL_CNT);
	assign empty = (count_q == '0);

	// wrap pointers around the store
	assign head_inc = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
	assign head_dec = (head_q == '0) ? LAST_IDX : head_q - 1'b1;
	assign tail_inc = (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;
	assign tail_dec = (tail_q == '0) ? LAST_IDX : tail_q - 1'b1;

	// decode the request into pointer moves and one store access
	always_comb begin
		head_d  = head_q;
		tail_d  = tail_q;
		count_d = count_q;
		stat_d  = STAT_OK;
		we      = 1'b0;
		re      = 1'b0;
		waddr   = tail_q;
		raddr   = head_q;
		case (opcode)
			OP_PUSH_FRONT: begin
				if (full) begin
					stat_d = STAT_FULL;
				end else begin
					head_d  = head_dec;
					waddr   = head_dec;
					we      = 1'b1;
					count_d = count_q + 1'b1;
				end
			end
			OP_PUSH_BACK: begin
				if (full) begin
					stat_d = STAT_FULL;
				end else begin
					tail_d  = tail_inc;
					we      = 1'b1;
					count_d = count_q + 1'b1;
				end
			end
			OP_POP_FRONT: begin
				if (empty) begin
					stat_d = STAT_EMPTY;
				end else begin
					re      = 1'b1;
					head_d  = head_inc;
					count_d = count_q - 1'b1;
				end
			end
			OP_POP_BACK: begin
				if (empty) begin
					stat_d = STAT_EMPTY;
				end else begin
					re      = 1'b1;
					raddr   = tail_dec;
					tail_d  = tail_dec;
					count_d = count_q - 1'b1;
				end
			end
			OP_PEEK_FRONT: begin
				if (empty) begin
					stat_d = STAT_EMPTY;
				end else begin
					re = 1'b1;
				end
			end
			OP_PEEK_BACK: begin
				if (empty) begin
					stat_d = STAT_EMPTY;
				end else begin
					re    = 1'b1;
					raddr = tail_dec;
				end
			end
			OP_CLEAR: begin
				head_d  = '0;
				tail_d  = '0;
				count_d = '0;
			end
			default: begin
			end
		endcase
	end

	// update pointers and count on each accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			count_q  <= '0;
			status_q <= STAT_OK;
			hit_q    <= 1'b0;
		end else if (cmd.take) begin
			head_q   <= head_d;
			tail_q   <= tail_d;
			count_q  <= count_d;
			status_q <= stat_d;
			hit_q    <= re;
		end
	end

	// store: one write or one registered read per request
	always_ff @(posedge clk) begin
		if (cmd.take && we) begin
			mem[waddr] <= data_in;
		end
		if (cmd.take && re) begin
			rd_q <= mem[raddr];
		end
	end

	// drive the result fields; zero data unless a word was read
	assign count_ext = {{OCC_W{1'b0}}, count_q};
	assign data_out  = hit_q ? $signed(rd_q) : '0;
	assign status    = status_q;
	assign occupancy = count_ext[OCC_W-1:0];

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("count above depth");

	a_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take && full && (opcode == OP_PUSH_FRONT || opcode == OP_PUSH_BACK)
		|=> status_q == STAT_FULL && $stable(count_q) && $stable(head_q) && $stable(tail_q))
		else $error("push on full changed state");

	a_read_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take && empty && (opcode == OP_POP_FRONT || opcode == OP_POP_BACK ||
		opcode == OP_PEEK_FRONT || opcode == OP_PEEK_BACK)
		|=> status_q == STAT_EMPTY && !hit_q && $stable(count_q))
		else $error("read on empty not refused");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take && opcode == OP_CLEAR
		|=> count_q == '0 && head_q == '0 && tail_q == '0)
		else $error("clear left state behind");

endmodule

### sv/ring_buffer_deque.sv
// Double-ended queue of signed 32-bit words in a circular store of DEPTH
// entries.
// Requests arrive on the s_ channel: an opcode (push front/back, pop
// front/back, peek front/back, clear) and a data word. Each request gives
// exactly one result on the m_ channel: the word popped or peeked (zero
// otherwise), a status (ok, empty, full) and the occupancy after the request.
// A pop or peek on an empty queue reports empty; a push on a full queue
// reports full and drops the word. Neither changes the queue.
// Each opcode's result is valid in the cycle after the request is taken:
// the store has one registered read port, and that read register is the
// result data. Throughput is one request per cycle while results are
// taken; the single result register limits the block to one result in
// flight, and a request is taken in the same cycle the held result is
// taken. When the receiver stalls, the result holds and s_tready drops
// until it is taken. Reset empties the queue at once, with no clearing pass.
module ring_buffer_deque #(
	parameter int DEPTH = rbd_pkg::DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [2:0] opcode, [34:3] data_in, rest zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata    // [31:0] data_out, [33:32] status, [41:34] occupancy
);
	import rbd_pkg::*;

	rbd_cmd_t cmd;
	logic signed [WORD_W-1:0] data_out;
	logic [STAT_W-1:0] status;
	logic [OCC_W-1:0] occupancy;

	rbd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	rbd_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.opcode    (s_tdata[2:0]),
		.data_in   ($signed(s_tdata[34:3])),
		.data_out  (data_out),
		.status    (status),
		.occupancy (occupancy)
	);

	// pack the result, zero pad to whole bytes
	assign m_tdata = {6'd0, occupancy, status, data_out};

endmodule
